// ----- src/bfw_pkg.sv -----
// bfw_pkg: shared constants, opcodes and controller/datapath command types
// for the bilateral filter window block; no dependencies
package bfw_pkg;

  localparam int unsigned DIAMETER_DEF    = 5;
  localparam int unsigned MAX_WIDTH_DEF   = 1024;
  localparam int unsigned WEIGHT_BITS_DEF = 16;

  // register map
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [11:0] HEIGHT_RESET = 12'd480;

  // quotient bits of the rounded Q8.4 result (one spare for overflow)
  localparam int unsigned QUOT_BITS = 13;

  typedef enum logic [1:0] {
    OP_PIXEL   = 2'd0,
    OP_RANGE   = 2'd1,
    OP_SPATIAL = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic issue_centre;
    logic issue_win;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic interior;
    logic out_busy;
  } status_t;

endpackage

// ----- src/bfw_if.sv -----
// bfw channel interfaces: input item, result item and configuration write
// depends on nothing
interface bfw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  pixel_value;
  logic [7:0]  table_index;
  logic [15:0] table_value;
  modport source (output valid, output opcode, output pixel_value, output table_index,
                  output table_value, input ready);
  modport sink (input valid, input opcode, input pixel_value, input table_index,
                input table_value, output ready);
endinterface

interface bfw_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] out_row;
  logic [9:0]  out_col;
  logic [11:0] filtered_value;
  logic        frame_last;
  modport source (output valid, output out_row, output out_col, output filtered_value,
                  output frame_last, input ready);
  modport sink (input valid, input out_row, input out_col, input filtered_value,
                input frame_last, output ready);
endinterface

interface bfw_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/bfw_ctrl.sv -----
// bfw_ctrl: sequencer for one item (accept, window sweep, divide, output)
// depends on bfw_pkg
module bfw_ctrl #(
  parameter int unsigned DIAMETER = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_opcode,
  output logic             in_ready,
  input  bfw_pkg::status_t status,
  output bfw_pkg::cmd_t    cmd
);
  import bfw_pkg::*;

  localparam int unsigned WIN_N = DIAMETER * DIAMETER;
  localparam int unsigned CNT_W = $clog2(WIN_N + 1);
  localparam int unsigned DRAIN_CYC = 3;

  typedef enum logic [2:0] {
    S_IDLE, S_CENTRE, S_SWEEP, S_DRAIN, S_DIV_LOAD, S_DIV, S_FINISH
  } state_t;

  state_t          state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic            accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // commands follow the state
  always_comb begin
    cmd = '0;
    cmd.accept       = accept;
    cmd.issue_centre = (state_r == S_CENTRE);
    cmd.issue_win    = (state_r == S_SWEEP);
    cmd.div_load     = (state_r == S_DIV_LOAD);
    cmd.div_step     = (state_r == S_DIV);
    cmd.out_load     = (state_r == S_FINISH) && !status.out_busy;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_opcode == OP_PIXEL && status.interior) state_nxt = S_CENTRE;
      end
      S_CENTRE: begin
        state_nxt = S_SWEEP;
        cnt_nxt   = '0;
      end
      S_SWEEP: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(WIN_N - 1)) begin
          state_nxt = S_DRAIN;
          cnt_nxt   = '0;
        end
      end
      S_DRAIN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DRAIN_CYC - 1)) state_nxt = S_DIV_LOAD;
      end
      S_DIV_LOAD: begin
        state_nxt = S_DIV;
        cnt_nxt   = '0;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QUOT_BITS - 1)) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!status.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- src/bfw_dp.sv -----
// bfw_dp: counters, line store, weight tables, weighted sums, divider and
// output register; depends on bfw_pkg
module bfw_dp #(
  parameter int unsigned DIAMETER    = 5,
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bfw_pkg::cmd_t    cmd,
  output bfw_pkg::status_t status,
  input  logic [1:0]       in_opcode,
  input  logic [7:0]       in_pixel_value,
  input  logic [7:0]       in_table_index,
  input  logic [15:0]      in_table_value,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [11:0]      out_row,
  output logic [9:0]       out_col,
  output logic [11:0]      out_filtered_value,
  output logic             out_frame_last
);
  import bfw_pkg::*;

  localparam int unsigned HALF_D = DIAMETER / 2;
  localparam int unsigned WIN_N  = DIAMETER * DIAMETER;
  localparam int unsigned KW     = $clog2(WIN_N);
  localparam int unsigned RMW    = $clog2(DIAMETER);
  localparam int unsigned CIW    = $clog2(MAX_WIDTH);
  localparam int unsigned LSD    = DIAMETER * MAX_WIDTH;
  localparam int unsigned LAW    = $clog2(LSD);
  localparam int unsigned WW     = 2 * WEIGHT_BITS;
  localparam int unsigned DENW   = WW + $clog2(WIN_N);
  localparam int unsigned NUMW   = DENW + 8;
  localparam int unsigned DW     = NUMW + 6;
  localparam int unsigned CMPW   = 13;

  // configuration registers
  logic [10:0] image_width_r;
  logic [11:0] image_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_RESET;
      image_height_r <= HEIGHT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_IMAGE_WIDTH) image_width_r <= cfg_data[10:0];
      else image_height_r <= cfg_data[11:0];
    end
  end

  // effective frame size
  logic [CMPW-1:0] eff_w, eff_h;
  always_comb begin
    if (image_width_r == '0) eff_w = CMPW'(1);
    else if (CMPW'(image_width_r) > CMPW'(MAX_WIDTH)) eff_w = CMPW'(MAX_WIDTH);
    else eff_w = CMPW'(image_width_r);
    eff_h = (image_height_r == '0) ? CMPW'(1) : CMPW'(image_height_r);
  end

  // raster counters with row modulo DIAMETER kept alongside
  logic [CIW-1:0]  col_r;
  logic [11:0]     row_r;
  logic [RMW-1:0]  rmod_r;
  logic [CMPW-1:0] c0, r0, c1, r1;
  logic [RMW-1:0]  m0, m1;
  logic            pix_accept;

  assign pix_accept = cmd.accept && (in_opcode == OP_PIXEL);

  always_comb begin
    c0 = CMPW'(col_r);
    r0 = CMPW'(row_r);
    m0 = rmod_r;
    if (c0 >= eff_w) begin
      c0 = '0;
      r0 = r0 + 1'b1;
      m0 = (m0 == RMW'(DIAMETER - 1)) ? '0 : m0 + 1'b1;
    end
    if (r0 >= eff_h) begin
      r0 = '0;
      m0 = '0;
    end
    c1 = c0 + 1'b1;
    r1 = r0;
    m1 = m0;
    if (c1 >= eff_w) begin
      c1 = '0;
      r1 = r1 + 1'b1;
      m1 = (m1 == RMW'(DIAMETER - 1)) ? '0 : m1 + 1'b1;
      if (r1 >= eff_h) begin
        r1 = '0;
        m1 = '0;
      end
    end
  end

  assign status.interior = (r0 >= CMPW'(DIAMETER - 1)) && (c0 >= CMPW'(DIAMETER - 1));
  assign status.out_busy = out_valid && !out_ready;

  // item registers for the current pixel
  logic [CIW-1:0] item_col_r;
  logic [RMW-1:0] item_rmod_r;
  logic [11:0]    item_row_out_r;
  logic [9:0]     item_col_out_r;
  logic           item_last_r;
  logic [CMPW-1:0] r_out, c_out;

  assign r_out = r0 - CMPW'(HALF_D);
  assign c_out = c0 - CMPW'(HALF_D);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      rmod_r <= '0;
    end else if (pix_accept) begin
      col_r  <= c1[CIW-1:0];
      row_r  <= r1[11:0];
      rmod_r <= m1;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      item_col_r     <= c0[CIW-1:0];
      item_rmod_r    <= m0;
      item_row_out_r <= r_out[11:0];
      item_col_out_r <= c_out[9:0];
      item_last_r    <= (r0 + 1'b1 == eff_h) && (c0 + 1'b1 == eff_w);
    end
  end

  // weight tables
  logic [WEIGHT_BITS+15:0] tv_ext;
  logic [WEIGHT_BITS-1:0]  tv;
  logic [WEIGHT_BITS-1:0]  range_mem [256];
  logic [WEIGHT_BITS-1:0]  spatial_mem [WIN_N];
  logic [7:0]              rd_diff;
  logic [KW-1:0]           k1_r;
  logic [WEIGHT_BITS-1:0]  rw_q, sw_q;

  assign tv_ext = {{WEIGHT_BITS{1'b0}}, in_table_value};
  assign tv     = tv_ext[WEIGHT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept && in_opcode == OP_RANGE) range_mem[in_table_index] <= tv;
    rw_q <= range_mem[rd_diff];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_opcode == OP_SPATIAL && 9'(in_table_index) < 9'(WIN_N))
      spatial_mem[in_table_index[KW-1:0]] <= tv;
    sw_q <= spatial_mem[k1_r];
  end

  // window address generation
  logic [RMW-1:0] wrow_r, crow;
  logic [CIW-1:0] wcol_r, wcol_start;
  logic [RMW-1:0] wj_r;
  logic [KW-1:0]  k_r;
  logic [RMW:0]   crow_sum, srow_sum;
  logic [RMW-1:0] srow;
  logic [LAW-1:0] ls_raddr, ls_waddr;
  logic [7:0]     ls_mem [LSD];
  logic [7:0]     ls_q;

  assign crow_sum   = (RMW+1)'(item_rmod_r) + (RMW+1)'(DIAMETER - HALF_D);
  assign crow       = (crow_sum >= (RMW+1)'(DIAMETER)) ? RMW'(crow_sum - (RMW+1)'(DIAMETER))
                                                      : crow_sum[RMW-1:0];
  assign srow_sum   = (RMW+1)'(item_rmod_r) + 1'b1;
  assign srow       = (srow_sum >= (RMW+1)'(DIAMETER)) ? '0 : srow_sum[RMW-1:0];
  assign wcol_start = item_col_r - CIW'(DIAMETER - 1);

  always_comb begin
    if (cmd.issue_centre)
      ls_raddr = LAW'(crow) * LAW'(MAX_WIDTH) + LAW'(item_col_r - CIW'(HALF_D));
    else
      ls_raddr = LAW'(wrow_r) * LAW'(MAX_WIDTH) + LAW'(wcol_r);
  end
  assign ls_waddr = LAW'(m0) * LAW'(MAX_WIDTH) + LAW'(c0);

  always_ff @(posedge clk) begin
    if (pix_accept) ls_mem[ls_waddr] <= in_pixel_value;
    ls_q <= ls_mem[ls_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.issue_centre) begin
      wrow_r <= srow;
      wcol_r <= wcol_start;
      wj_r   <= '0;
      k_r    <= '0;
    end else if (cmd.issue_win) begin
      k_r <= k_r + 1'b1;
      if (wj_r == RMW'(DIAMETER - 1)) begin
        wj_r   <= '0;
        wcol_r <= wcol_start;
        wrow_r <= (wrow_r == RMW'(DIAMETER - 1)) ? '0 : wrow_r + 1'b1;
      end else begin
        wj_r   <= wj_r + 1'b1;
        wcol_r <= wcol_r + 1'b1;
      end
    end
  end

  // weighting pipeline: pixel read, table read, weight product, accumulate
  logic           v1_win_r, v1_ctr_r, v2_r, v3_r;
  logic [7:0]     centre_r, p2_r, p3_r;
  logic [WW-1:0]  w_r;
  logic [NUMW-1:0] num_r;
  logic [DENW-1:0] den_r;

  assign rd_diff = (ls_q >= centre_r) ? ls_q - centre_r : centre_r - ls_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_win_r <= 1'b0;
      v1_ctr_r <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
    end else begin
      v1_win_r <= cmd.issue_win;
      v1_ctr_r <= cmd.issue_centre;
      v2_r     <= v1_win_r;
      v3_r     <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue_win) k1_r <= k_r;
    if (v1_ctr_r) centre_r <= ls_q;
    p2_r <= ls_q;
    p3_r <= p2_r;
    w_r  <= WW'(rw_q) * WW'(sw_q);
  end

  always_ff @(posedge clk) begin
    if (cmd.issue_centre) begin
      num_r <= '0;
      den_r <= '0;
    end else if (v3_r) begin
      num_r <= num_r + NUMW'(w_r) * NUMW'(p3_r);
      den_r <= den_r + DENW'(w_r);
    end
  end

  // restoring divide: q = floor((32*num + den) / (2*den)), one bit a cycle
  logic [DW-1:0]        n_r, ds_r;
  logic [QUOT_BITS-1:0] q_r;
  logic                 den_zero_r;

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      n_r        <= (DW'(num_r) << 5) + DW'(den_r);
      ds_r       <= DW'(den_r) << QUOT_BITS;
      q_r        <= '0;
      den_zero_r <= (den_r == '0);
    end else if (cmd.div_step) begin
      if (n_r >= ds_r) begin
        n_r <= n_r - ds_r;
        q_r <= {q_r[QUOT_BITS-2:0], 1'b1};
      end else begin
        q_r <= {q_r[QUOT_BITS-2:0], 1'b0};
      end
      ds_r <= ds_r >> 1;
    end
  end

  // output register
  logic [11:0] fv;
  always_comb begin
    if (den_zero_r) fv = {centre_r, 4'b0000};
    else if (q_r[QUOT_BITS-1]) fv = 12'hFFF;
    else fv = q_r[11:0];
  end

  logic        out_valid_r;
  logic [11:0] out_row_r, out_fv_r;
  logic [9:0]  out_col_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row_r  <= item_row_out_r;
      out_col_r  <= item_col_out_r;
      out_fv_r   <= fv;
      out_last_r <= item_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_row            = out_row_r;
  assign out_col            = out_col_r;
  assign out_filtered_value = out_fv_r;
  assign out_frame_last     = out_last_r;

endmodule

// ----- src/bilateral_filter_window_top.sv -----
// bilateral_filter_window_top: streaming bilateral filter over a square window
// depends on bfw_pkg, bfw_if, bfw_ctrl, bfw_dp
//
// Usage: in_ch carries one item per transaction: opcode pixel streams an 8-bit
// grayscale pixel in raster order, opcodes range and spatial load one entry of
// the Gaussian weight tables (load them before the first interior pixel).
// out_ch gives one transaction per interior pixel: centre row/column, the
// filtered value in unsigned Q8.4 and frame_last on the frame's last result.
// cfg_ch writes image_width (index 0) and image_height (index 1); it is always
// ready and may only be used while the block is idle.
// Sequencing: table writes and border pixels need no more work after they are
// accepted. An interior pixel has its centre read, then one line store read per
// window position through a single read port, then a one-bit-a-cycle divider.
// One item is worked on at a time.
// Reset: synchronous, active low; counters clear, width/height return to
// 640x480; line store and weight tables keep undefined contents.
// Stall: the result waits in an output register; the next item is accepted
// meanwhile, and a new result waits until the register is taken.
module bilateral_filter_window_top #(
  parameter int unsigned DIAMETER    = bfw_pkg::DIAMETER_DEF,
  parameter int unsigned MAX_WIDTH   = bfw_pkg::MAX_WIDTH_DEF,
  parameter int unsigned WEIGHT_BITS = bfw_pkg::WEIGHT_BITS_DEF
) (
  input logic     clk,
  input logic     rst_n,
  bfw_in_if.sink  in_ch,
  bfw_out_if.source out_ch,
  bfw_cfg_if.sink cfg_ch
);
  import bfw_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ch.ready = 1'b1;

  bfw_ctrl #(
    .DIAMETER(DIAMETER)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_opcode(in_ch.opcode),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  bfw_dp #(
    .DIAMETER   (DIAMETER),
    .MAX_WIDTH  (MAX_WIDTH),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_opcode         (in_ch.opcode),
    .in_pixel_value    (in_ch.pixel_value),
    .in_table_index    (in_ch.table_index),
    .in_table_value    (in_ch.table_value),
    .cfg_write         (cfg_ch.valid),
    .cfg_index         (cfg_ch.index),
    .cfg_data          (cfg_ch.data),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_row           (out_ch.out_row),
    .out_col           (out_ch.out_col),
    .out_filtered_value(out_ch.filtered_value),
    .out_frame_last    (out_ch.frame_last)
  );

endmodule

// ----- src/bfw_checker.sv -----
// bfw_checker: port-level checks of the bilateral filter window block
// depends on bfw_pkg; bound to bilateral_filter_window_top
module bfw_port_checks #(
  parameter int unsigned DIAMETER = bfw_pkg::DIAMETER_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_opcode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_row,
  input logic [9:0]  out_col,
  input logic [11:0] filtered_value
);
  import bfw_pkg::*;

  localparam int unsigned HALF_D = DIAMETER / 2;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(filtered_value) && $stable(out_row))
    else $error("result changed while stalled");

  // results only for interior centres
  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_row >= 12'(HALF_D) && out_col >= 10'(HALF_D))
    else $error("result for a border position");

  // after a table write or an unused opcode the input is ready again in the next cycle
  a_table_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode != OP_PIXEL |=> in_ready)
    else $error("input not ready after a table write");

  // nothing pending straight after reset
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bilateral_filter_window_top bfw_port_checks #(.DIAMETER(DIAMETER)) u_bfw_port_checks (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_opcode     (in_ch.opcode),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_row       (out_ch.out_row),
  .out_col       (out_ch.out_col),
  .filtered_value(out_ch.filtered_value)
);
